>>> sv/hsv_color_range_vote_unit_assert.svh
// ----------------------------------------------------------------------------
// HSV color range vote unit: assertion macros
// Shared macros for the concurrent checks in the RTL files. Each macro
// expects a clock named clk and an active-low reset named arst_n in scope.
// ----------------------------------------------------------------------------
`ifndef HSV_COLOR_RANGE_VOTE_UNIT_ASSERT_SVH
`define HSV_COLOR_RANGE_VOTE_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HCRV_ASSERT_HOLD(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define HCRV_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> sv/hcrv_pkg.sv
// ----------------------------------------------------------------------------
// HSV color range vote: shared package
// Word types for the pixel and result channels, the token that walks the
// cell chain, and the configuration register indexes.
// ----------------------------------------------------------------------------
package hcrv_pkg;

	// Configuration port
	localparam int CFG_IDX_W = 3;
	localparam int RANGE_W   = 48;
	localparam int THRESH_W  = 20;
	localparam int ACTIVE_W  = 3;

	localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_THRESH = 3'd7;

	localparam logic [THRESH_W-1:0] THRESH_RESET = 20'd800;
	localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 3'd1;

	// Result fields
	localparam int COLOR_W = 3;
	localparam int SCORE_W = 20;
	localparam logic [SCORE_W-1:0] SCORE_MAX = 20'hFFFFF;

	// Input word
	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       point_valid;
		logic       last_point;
	} pix_t;

	// Result word
	typedef struct packed {
		logic [COLOR_W-1:0] winning_color;
		logic [SCORE_W-1:0] winning_score;
		logic               detected;
	} res_t;

	// Converted pixel as it travels down the cell chain.
	// Hue is hnum/hden in units of two degrees, saturation is snum/sden scaled to 255.
	typedef struct packed {
		logic        occ;
		logic        vote;
		logic        last;
		logic [15:0] hnum;
		logic [7:0]  hden;
		logic [15:0] snum;
		logic [7:0]  sden;
		logic [7:0]  val;
	} tok_t;

endpackage

>>> sv/hsv_color_range_vote_unit.sv
// ----------------------------------------------------------------------------
// HSV color range vote unit
// Counts pixels per HSV color range and reports the best range per object.
// ----------------------------------------------------------------------------
// Usage:
// The pix channel takes one RGB pixel per word with a vote flag and an
// end-of-object mark. The res channel gives one word per object, on its
// last pixel: the best active range, its count and the detected flag.
// The cfg channel is always ready and writes color ranges, the number of
// active colors and the score threshold; write it only while no object is
// in flight.
// A pixel goes through one conversion stage, one cell per color and the
// output register. The conversion stage loads on the edge that takes the
// pixel. A result is registered once its last pixel leaves the last cell.
// One pixel is taken per cycle while pix_ready is high; each cell is a
// register stage, so the chain length sets the latency and not the rate.
// Reset clears all counters, all ranges to zero, active colors to one and
// the threshold to 800. When the receiver stalls, a second result is held
// in a skid register; only when that is full does pix_ready drop.
// ----------------------------------------------------------------------------
module hsv_color_range_vote_unit
	import hcrv_pkg::*;
#(
	parameter int NUM_COLORS = 6,
	parameter int COUNT_BITS = 20
)
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 pix_valid,
	output logic                 pix_ready,
	input  pix_t                 pix,
	output logic                 res_valid,
	input  logic                 res_ready,
	output res_t                 res,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [RANGE_W-1:0]   cfg_data
);

	localparam int WW = (COUNT_BITS > SCORE_W) ? COUNT_BITS : SCORE_W;

	logic [RANGE_W-1:0]  ranges_q [NUM_COLORS];
	logic [ACTIVE_W-1:0] active_q;
	logic [THRESH_W-1:0] thresh_q;
	logic [ACTIVE_W-1:0] used_n;
	logic                en;
	logic                take;
	logic                push;
	res_t                res_word;
	logic [WW-1:0]       score_ext;
	res_t                out_word_q;
	logic                out_valid_q;
	res_t                skid_word_q;
	logic                skid_valid_q;
	logic                out_fire;

	tok_t                  tok_c        [NUM_COLORS+1];
	logic [COLOR_W-1:0]    best_idx_c   [NUM_COLORS+1];
	logic [COUNT_BITS-1:0] best_score_c [NUM_COLORS+1];

	// Configuration registers.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_COLORS; i++) ranges_q[i] <= '0;
			active_q <= ACTIVE_RESET;
			thresh_q <= THRESH_RESET;
		end else if (cfg_valid) begin
			for (int i = 0; i < NUM_COLORS; i++) begin
				if (cfg_index == CFG_IDX_W'(i)) ranges_q[i] <= cfg_data;
			end
			case (cfg_index)
				CFG_ACTIVE: active_q <= cfg_data[ACTIVE_W-1:0];
				CFG_THRESH: thresh_q <= cfg_data[THRESH_W-1:0];
				default: ;
			endcase
		end
	end

	// Number of ranges in use, clamped to the cells that exist.
	always_comb begin
		if (active_q == '0) used_n = ACTIVE_W'(1);
		else if (active_q > ACTIVE_W'(NUM_COLORS)) used_n = ACTIVE_W'(NUM_COLORS);
		else used_n = active_q;
	end

	// The chain moves whenever the skid register has room.
	assign en        = !skid_valid_q;
	assign pix_ready = en;
	assign take      = pix_valid && en;

	hcrv_hsv_conv u_conv (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.take   (take),
		.pix    (pix),
		.tok    (tok_c[0])
	);

	assign best_idx_c[0]   = '0;
	assign best_score_c[0] = '0;

	// One cell per color range.
	for (genvar gi = 0; gi < NUM_COLORS; gi++) begin : g_cell
		hcrv_cell #(
			.COUNT_BITS (COUNT_BITS),
			.INDEX      (gi)
		) u_cell (
			.clk            (clk),
			.arst_n         (arst_n),
			.en             (en),
			.active         (ACTIVE_W'(gi) < used_n),
			.bounds         (ranges_q[gi]),
			.tok_in         (tok_c[gi]),
			.best_idx_in    (best_idx_c[gi]),
			.best_score_in  (best_score_c[gi]),
			.tok_out        (tok_c[gi+1]),
			.best_idx_out   (best_idx_c[gi+1]),
			.best_score_out (best_score_c[gi+1])
		);
	end

	// Result word from the end of the chain.
	always_comb begin
		score_ext              = WW'(best_score_c[NUM_COLORS]);
		res_word.winning_color = best_idx_c[NUM_COLORS];
		res_word.winning_score = (score_ext > WW'(SCORE_MAX)) ? SCORE_MAX
			: score_ext[SCORE_W-1:0];
		res_word.detected      = score_ext >= WW'(thresh_q);
	end

	assign push = en && tok_c[NUM_COLORS].occ && tok_c[NUM_COLORS].last;

	// Output register with a skid stage behind it.
	assign out_fire  = out_valid_q && res_ready;
	assign res_valid = out_valid_q;
	assign res       = out_word_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (out_fire) begin
				if (skid_valid_q) begin
					skid_valid_q <= 1'b0;
				end else begin
					out_valid_q <= push;
				end
			end else if (!out_valid_q) begin
				out_valid_q <= push;
			end else if (push) begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_fire && skid_valid_q) begin
			out_word_q <= skid_word_q;
		end else if ((out_fire || !out_valid_q) && push) begin
			out_word_q <= res_word;
		end else if (push) begin
			skid_word_q <= res_word;
		end
	end

`include "hsv_color_range_vote_unit_assert.svh"

	`HCRV_ASSERT_HOLD(a_skid_behind_out, skid_valid_q, out_valid_q, "skid word held while output register is empty")
	`HCRV_ASSERT_NEXT(a_skid_drains, out_fire && skid_valid_q, out_valid_q && !skid_valid_q, "skid word not moved to the output register")
	`HCRV_ASSERT_HOLD(a_color_in_range, out_valid_q, out_word_q.winning_color < COLOR_W'(NUM_COLORS), "winning color beyond the cell chain")

endmodule

>>> sv/hcrv_hsv_conv.sv
// ----------------------------------------------------------------------------
// HSV color range vote: RGB to HSV conversion stage
// Registers one pixel as exact rational hue and saturation terms so the
// cells can compare against bounds by cross-multiplication.
// ----------------------------------------------------------------------------
module hcrv_hsv_conv
	import hcrv_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic take,
	input  pix_t pix,
	output tok_t tok
);

	logic [7:0]         mx;
	logic [7:0]         mn;
	logic [7:0]         d;
	logic [9:0]         kd;
	logic signed [9:0]  t;
	logic signed [11:0] base;
	logic signed [17:0] hraw;
	logic [15:0]        d180;
	logic signed [17:0] hadj;
	logic [15:0]        hnum;
	logic [7:0]         hden;
	logic [15:0]        snum;
	logic [7:0]         sden;

	// Maximum, minimum and their spread.
	always_comb begin
		mx = pix.red;
		mn = pix.red;
		if (pix.green > mx) mx = pix.green;
		if (pix.blue > mx) mx = pix.blue;
		if (pix.green < mn) mn = pix.green;
		if (pix.blue < mn) mn = pix.blue;
		d = mx - mn;
	end

	// Hue sector offset and signed difference, picked by which channel is largest.
	always_comb begin
		if (mx == pix.red) begin
			kd = 10'd0;
			t  = $signed({2'b00, pix.green}) - $signed({2'b00, pix.blue});
		end else if (mx == pix.green) begin
			kd = {1'b0, d, 1'b0};
			t  = $signed({2'b00, pix.blue}) - $signed({2'b00, pix.red});
		end else begin
			kd = {d, 2'b00};
			t  = $signed({2'b00, pix.red}) - $signed({2'b00, pix.green});
		end
		base = $signed({2'b00, kd}) + 12'(t);
		hraw = 18'(base) * 18'sd30;
		d180 = 16'(d) * 16'd180;
		hadj = (hraw < 0) ? hraw + $signed({2'b00, d180}) : hraw;
	end

	// Gray pixels have hue zero; black pixels have saturation zero.
	always_comb begin
		if (d == 8'd0) begin
			hnum = 16'd0;
			hden = 8'd1;
		end else begin
			hnum = hadj[15:0];
			hden = d;
		end
		if (mx == 8'd0) begin
			snum = 16'd0;
			sden = 8'd1;
		end else begin
			snum = 16'(d) * 16'd255;
			sden = mx;
		end
	end

	// Stage register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok <= '0;
		end else if (en) begin
			tok.occ  <= take;
			tok.vote <= pix.point_valid;
			tok.last <= pix.last_point;
			tok.hnum <= hnum;
			tok.hden <= hden;
			tok.snum <= snum;
			tok.sden <= sden;
			tok.val  <= mx;
		end
	end

endmodule

>>> sv/hcrv_cell.sv
// ----------------------------------------------------------------------------
// HSV color range vote: one color cell
// Holds the match counter of one color range. Tests the passing pixel,
// counts a hit, and on the last pixel folds its count into the running
// best before clearing.
// ----------------------------------------------------------------------------
module hcrv_cell
	import hcrv_pkg::*;
#(
	parameter int COUNT_BITS = 20,
	parameter int INDEX      = 0
)
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic                  active,
	input  logic [RANGE_W-1:0]    bounds,
	input  tok_t                  tok_in,
	input  logic [COLOR_W-1:0]    best_idx_in,
	input  logic [COUNT_BITS-1:0] best_score_in,
	output tok_t                  tok_out,
	output logic [COLOR_W-1:0]    best_idx_out,
	output logic [COUNT_BITS-1:0] best_score_out
);

	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

	logic [COUNT_BITS-1:0] cnt_q;
	logic [COUNT_BITS-1:0] cnt_vote;
	logic [7:0]            hl, hh, sl, sh, vl, vh;
	logic [15:0]           hlo, hhi, slo, shi;
	logic                  hok, sok, vok, hit;
	logic                  take_self;

	// Bound bytes and the cross-multiplied bounds.
	always_comb begin
		hl  = bounds[7:0];
		hh  = bounds[15:8];
		sl  = bounds[23:16];
		sh  = bounds[31:24];
		vl  = bounds[39:32];
		vh  = bounds[47:40];
		hlo = 16'(hl) * 16'(tok_in.hden);
		hhi = 16'(hh) * 16'(tok_in.hden);
		slo = 16'(sl) * 16'(tok_in.sden);
		shi = 16'(sh) * 16'(tok_in.sden);
	end

	// Range test; the hue window wraps when its low bound is above its high bound.
	always_comb begin
		if (hl <= hh) hok = (hlo <= tok_in.hnum) && (tok_in.hnum <= hhi);
		else hok = (hlo <= tok_in.hnum) || (tok_in.hnum <= hhi);
		sok = (slo <= tok_in.snum) && (tok_in.snum <= shi);
		vok = (vl <= tok_in.val) && (tok_in.val <= vh);
		hit = tok_in.occ && tok_in.vote && active && hok && sok && vok;
	end

	// Saturating count including this pixel, and the running best.
	always_comb begin
		cnt_vote  = (hit && cnt_q != COUNT_MAX) ? cnt_q + 1'b1 : cnt_q;
		take_self = (INDEX == 0) || (active && cnt_vote > best_score_in);
	end

	// Counter and hand-off registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q          <= '0;
			tok_out        <= '0;
			best_idx_out   <= '0;
			best_score_out <= '0;
		end else if (en) begin
			cnt_q   <= (tok_in.occ && tok_in.last) ? '0 : cnt_vote;
			tok_out <= tok_in;
			if (take_self) begin
				best_idx_out   <= COLOR_W'(INDEX);
				best_score_out <= cnt_vote;
			end else begin
				best_idx_out   <= best_idx_in;
				best_score_out <= best_score_in;
			end
		end
	end

`include "hsv_color_range_vote_unit_assert.svh"

	`HCRV_ASSERT_NEXT(a_clear_after_last, en && tok_in.occ && tok_in.last, cnt_q == '0, "counter not cleared after the last pixel")

endmodule
